// ===== src/isbp_pkg.sv =====
package isbp_pkg;

    localparam int unsigned LAG_BITS        = 11;
    localparam int unsigned COEF_BITS       = 3;
    localparam int unsigned RESET_GRP_BITS  = 5;
    localparam int unsigned VALUE_W         = 32;
    localparam int unsigned BAND_W          = 6;
    localparam int unsigned CFG_INDEX_W     = 2;
    localparam int unsigned CFG_DATA_W      = 6;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRED_KIND  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRED_BANDS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_LIMIT = 2'd2;

    // predictor kinds; the spare code acts as no predictor
    localparam logic [1:0] PRED_NONE     = 2'd0;
    localparam logic [1:0] PRED_BACKWARD = 2'd1;
    localparam logic [1:0] PRED_LTP      = 2'd2;
    localparam logic [1:0] PRED_SPARE    = 2'd3;

    localparam logic [1:0] WIN_SHORT = 2'd2;

    localparam logic [BAND_W-1:0] PRED_BANDS_RST = 6'd40;
    localparam logic [BAND_W-1:0] BAND_LIMIT_RST = 6'd51;

    // syntax element codes
    localparam logic [3:0] EL_WINSEQ     = 4'd0;
    localparam logic [3:0] EL_SHAPE      = 4'd1;
    localparam logic [3:0] EL_MAXBANDS   = 4'd2;
    localparam logic [3:0] EL_GROUPING   = 4'd3;
    localparam logic [3:0] EL_PREDPRES   = 4'd4;
    localparam logic [3:0] EL_RESET      = 4'd5;
    localparam logic [3:0] EL_RESETGROUP = 4'd6;
    localparam logic [3:0] EL_BANDFLAG   = 4'd7;
    localparam logic [3:0] EL_LTPPRES    = 4'd8;
    localparam logic [3:0] EL_LAG        = 4'd9;
    localparam logic [3:0] EL_COEF       = 4'd10;
    localparam logic [3:0] EL_FLAGWORD   = 4'd11;

    typedef struct packed {
        logic stream_bit;
        logic first;
        logic pair;
    } t_in;

    typedef struct packed {
        logic [3:0]         element;
        logic               channel;
        logic [BAND_W-1:0]  band;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               error;
    } t_out;

endpackage

// ===== src/ics_side_info_bit_parser_top.sv =====
// Side-info bit parser: takes one stream bit per word (MSB of each field first) and
// returns one word for each syntax element as it completes: window sequence, shape,
// max bands, grouping or predictor-present, then backward-predictor reset, reset group
// and band flags, or per-channel LTP present, lag, coef and up to two flag words.
// A word with first set starts a new record and aborts any unfinished one; pair is
// sampled with it. Each input word is parsed in the cycle it is accepted and its
// result is loaded into the output register at that same edge, so it is offered
// from the next cycle on and the block sustains one bit per clock; the input stalls
// only while a result is held under output stall.
// Configuration writes take effect at once. error always comes with last.
module ics_side_info_bit_parser_top
    import isbp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in                    i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out                   o_out,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [13:0] {
        PH_IDLE     = 14'b00000000000001,
        PH_WINSEQ   = 14'b00000000000010,
        PH_SHAPE    = 14'b00000000000100,
        PH_MAXB     = 14'b00000000001000,
        PH_GROUP    = 14'b00000000010000,
        PH_PREDPRES = 14'b00000000100000,
        PH_RESET    = 14'b00000001000000,
        PH_RESETGRP = 14'b00000010000000,
        PH_BANDFLAG = 14'b00000100000000,
        PH_LTPPRES  = 14'b00001000000000,
        PH_LAG      = 14'b00010000000000,
        PH_COEF     = 14'b00100000000000,
        PH_WORD0    = 14'b01000000000000,
        PH_WORD1    = 14'b10000000000000
    } t_phase;

    logic [1:0]         r_pred_kind;
    logic [BAND_W-1:0]  r_pred_bands;
    logic [BAND_W-1:0]  r_band_limit;

    t_phase             r_phase, n_phase;
    logic [5:0]         r_bit_count, n_bit_count;
    logic [VALUE_W-1:0] r_shift, n_shift;
    logic [1:0]         r_win_kind, n_win_kind;
    logic [BAND_W-1:0]  r_max_bands, n_max_bands;
    logic [BAND_W-1:0]  r_band_idx, n_band_idx;
    logic               r_pair, n_pair;
    logic               r_chan, n_chan;
    logic               r_reset_seen, n_reset_seen;

    logic               r_out_valid;
    t_out               r_out;

    logic               accept;
    logic               res_valid;
    t_out               res;
    logic [BAND_W-1:0]  flag_cnt;
    logic [5:0]         raw_len;
    logic [5:0]         field_len;
    logic [VALUE_W-1:0] v;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign flag_cnt = (r_max_bands < r_pred_bands) ? r_max_bands : r_pred_bands;
    assign v        = {r_shift[VALUE_W-2:0], i_in.stream_bit};

    always_comb begin
        case (r_phase)
            PH_WINSEQ:   raw_len = 6'd2;
            PH_MAXB:     raw_len = (r_win_kind == WIN_SHORT) ? 6'd4 : 6'd6;
            PH_GROUP:    raw_len = 6'd7;
            PH_RESETGRP: raw_len = 6'(RESET_GRP_BITS);
            PH_LAG:      raw_len = 6'(LAG_BITS);
            PH_COEF:     raw_len = 6'(COEF_BITS);
            PH_WORD0:    raw_len = (flag_cnt > 6'd32) ? 6'd32 : flag_cnt;
            PH_WORD1:    raw_len = (flag_cnt > 6'd32) ? flag_cnt - 6'd32 : 6'd0;
            default:     raw_len = 6'd1;
        endcase
        field_len = (raw_len == 6'd0) ? 6'd1 : raw_len;
    end

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_win_kind   = r_win_kind;
        n_max_bands  = r_max_bands;
        n_band_idx   = r_band_idx;
        n_pair       = r_pair;
        n_chan       = r_chan;
        n_reset_seen = r_reset_seen;
        res_valid    = 1'b0;
        res          = '0;
        res.channel  = r_chan;
        res.value    = v;

        if (accept) begin
            if (i_in.first) begin
                n_phase      = PH_WINSEQ;
                n_bit_count  = '0;
                n_shift      = '0;
                n_band_idx   = '0;
                n_pair       = i_in.pair;
                n_chan       = 1'b0;
                n_reset_seen = 1'b0;
            end else if (r_phase == PH_IDLE) begin
                n_phase = PH_IDLE;
            end else if ({1'b0, r_bit_count} + 7'd1 < {1'b0, field_len}) begin
                // field still open: shift the bit in
                n_shift     = v;
                n_bit_count = r_bit_count + 6'd1;
            end else begin
                n_shift     = '0;
                n_bit_count = '0;
                res_valid   = 1'b1;
                case (r_phase)
                    PH_WINSEQ: begin
                        n_win_kind  = v[1:0];
                        n_phase     = PH_SHAPE;
                        res.element = EL_WINSEQ;
                        res.channel = 1'b0;
                    end
                    PH_SHAPE: begin
                        n_phase     = PH_MAXB;
                        res.element = EL_SHAPE;
                        res.channel = 1'b0;
                    end
                    PH_MAXB: begin
                        n_max_bands = v[BAND_W-1:0];
                        res.element = EL_MAXBANDS;
                        res.channel = 1'b0;
                        if (v[BAND_W-1:0] > r_band_limit) begin
                            res.last  = 1'b1;
                            res.error = 1'b1;
                        end else begin
                            n_phase = (r_win_kind == WIN_SHORT) ? PH_GROUP : PH_PREDPRES;
                        end
                    end
                    PH_GROUP: begin
                        res.element = EL_GROUPING;
                        res.channel = 1'b0;
                        res.last    = 1'b1;
                    end
                    PH_PREDPRES: begin
                        res.element = EL_PREDPRES;
                        res.channel = 1'b0;
                        res.value   = VALUE_W'(v != '0);
                        if (v == '0) begin
                            res.last = 1'b1;
                        end else if (r_pred_kind == PRED_BACKWARD) begin
                            n_phase = PH_RESET;
                        end else if (r_pred_kind == PRED_LTP) begin
                            n_chan  = 1'b0;
                            n_phase = PH_LTPPRES;
                        end else begin
                            // predictor bit with no predictor configured
                            res.last  = 1'b1;
                            res.error = 1'b1;
                        end
                    end
                    PH_RESET, PH_RESETGRP: begin
                        res.element = (r_phase == PH_RESET) ? EL_RESET : EL_RESETGROUP;
                        res.channel = 1'b0;
                        if (r_phase == PH_RESET) begin
                            n_reset_seen = v[0];
                        end
                        if (r_phase == PH_RESET && v[0]) begin
                            n_phase = PH_RESETGRP;
                        end else begin
                            n_band_idx = '0;
                            if (flag_cnt == '0) begin
                                res.last = 1'b1;
                            end else begin
                                n_phase = PH_BANDFLAG;
                            end
                        end
                    end
                    PH_BANDFLAG: begin
                        res.element = EL_BANDFLAG;
                        res.channel = 1'b0;
                        res.band    = r_band_idx;
                        res.last    = ({1'b0, r_band_idx} + 7'd1 >= {1'b0, flag_cnt});
                        n_band_idx  = r_band_idx + 6'd1;
                    end
                    PH_LTPPRES, PH_COEF, PH_WORD0, PH_WORD1: begin
                        case (r_phase)
                            PH_LTPPRES: res.element = EL_LTPPRES;
                            PH_COEF:    res.element = EL_COEF;
                            default:    res.element = EL_FLAGWORD;
                        endcase
                        res.band = (r_phase == PH_WORD1) ? 6'd1 : 6'd0;
                        if (r_phase == PH_LTPPRES && v != '0) begin
                            n_phase = PH_LAG;
                        end else if (r_phase == PH_COEF && flag_cnt != '0) begin
                            n_phase = PH_WORD0;
                        end else if (r_phase == PH_WORD0 && flag_cnt > 6'd32) begin
                            n_phase = PH_WORD1;
                        end else if (r_pair && !r_chan) begin
                            // advance to the second channel
                            n_chan  = 1'b1;
                            n_phase = PH_LTPPRES;
                        end else begin
                            res.last = 1'b1;
                        end
                    end
                    PH_LAG: begin
                        n_phase     = PH_COEF;
                        res.element = EL_LAG;
                    end
                    default: begin
                        res_valid = 1'b0;
                        n_phase   = PH_IDLE;
                    end
                endcase
                if (res.last) begin
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred_kind  <= PRED_NONE;
            r_pred_bands <= PRED_BANDS_RST;
            r_band_limit <= BAND_LIMIT_RST;
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_win_kind   <= '0;
            r_max_bands  <= '0;
            r_band_idx   <= '0;
            r_pair       <= 1'b0;
            r_chan       <= 1'b0;
            r_reset_seen <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PRED_KIND:  r_pred_kind  <= i_cfg_data[1:0];
                    CFG_PRED_BANDS: r_pred_bands <= i_cfg_data;
                    CFG_BAND_LIMIT: r_band_limit <= i_cfg_data;
                    default:        r_pred_kind  <= r_pred_kind;
                endcase
            end
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_win_kind   <= n_win_kind;
            r_max_bands  <= n_max_bands;
            r_band_idx   <= n_band_idx;
            r_pair       <= n_pair;
            r_chan       <= n_chan;
            r_reset_seen <= n_reset_seen;
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

endmodule

// ===== src/isbp_checker.sv =====
module isbp_checker
    import isbp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result word changed or dropped");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.error |-> o_out.last)
        else $error("error word does not end the record");

    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    a_band_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.band != '0 |->
            o_out.element == EL_BANDFLAG || o_out.element == EL_FLAGWORD)
        else $error("band index on an element without bands");

    a_err_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.error |->
            o_out.element == EL_MAXBANDS || o_out.element == EL_PREDPRES)
        else $error("error on an element that cannot fail");

endmodule

bind ics_side_info_bit_parser_top isbp_checker u_isbp_checker (.*);
